@@ rtl/aws_pkg.sv @@
// ----------------------------------------------------------------------------
// aws_pkg: shared constants of the AIMD window sender
// Field widths, event codes, register indexes and reset values used by the
// sender core, the reciprocal unit and the port checker.
// ----------------------------------------------------------------------------
package aws_pkg;

	// Field widths
	localparam int WIN_W      = 26;
	localparam int RWND_W     = 16;
	localparam int FLIGHT_W   = 16;
	localparam int SEQ_W      = 32;
	localparam int BYTES_W    = 16;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 26;
	localparam int CFG_IDX_W  = 1;

	// Parameter defaults
	localparam int DEF_QUEUE_DEPTH = 256;
	localparam int DEF_FRAC_BITS   = 16;

	// Event codes
	localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RWND   = 1'b1;

	// Reset values
	localparam logic [WIN_W-1:0]  WIN_RESET  = 26'd65536;
	localparam logic [RWND_W-1:0] RWND_RESET = 16'd200;
	localparam logic [WIN_W-1:0]  WIN_MAX    = {WIN_W{1'b1}};

endpackage

@@ rtl/aws_recip.sv @@
// ----------------------------------------------------------------------------
// aws_recip: iterative reciprocal of the congestion window
// Restoring division of 2^(2*FRAC_BITS) by the window, one quotient bit per
// cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module aws_recip
	import aws_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIN_W-1:0]     divisor,
	output logic                 done,
	output logic [FRAC_BITS:0]   quotient
);

	localparam int LAST  = 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(LAST + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W:0]   rem_q;
	logic [FRAC_BITS:0] quo_q;

	logic           din;
	logic [WIN_W:0] rem_sh;
	logic           ge;
	logic [WIN_W:0] rem_n;

	// One restoring step: the dividend is a single one at its top bit
	always_comb begin
		din    = (cnt_q == '0);
		rem_sh = {rem_q[WIN_W-1:0], din};
		ge     = (rem_sh >= {1'b0, divisor});
		rem_n  = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/aimd_window_sender.sv @@
// ----------------------------------------------------------------------------
// aimd_window_sender: window-limited packet sender with AIMD and ECN
// Queues packet lengths, tracks in-flight packets, grows or halves the
// congestion window on acknowledgements and releases at most one packet per
// event.
// ----------------------------------------------------------------------------
// Each event takes one transfer in and gives one result transfer out. A data,
// channel-free or ECN-marked acknowledgement event goes from the idle state
// through the decide state to the output state; an unmarked acknowledgement
// also waits in the divide state, before deciding, for the bit-serial
// reciprocal unit that computes 1/cwnd. One event is worked at a time; a new
// event is taken while the previous result still waits in the output register.
// The send queue is a single-port memory of QUEUE_DEPTH lengths, written on a
// data event and read in the decide state on a release. Configuration
// writes take effect at once and are made only while the block is idle.
module aimd_window_sender
	import aws_pkg::*;
#(
	parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
	parameter int WINDOW_FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	// events
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [MODE_W-1:0]                   mode,
	input  logic [BYTES_W-1:0]                  packet_bytes,
	input  logic [RWND_W-1:0]                   ack_window,
	input  logic                                ack_congested,
	input  logic                                line_busy,
	// results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sent,
	output logic [SEQ_W-1:0]                    sent_seq,
	output logic [BYTES_W-1:0]                  sent_bytes,
	output logic [WIN_W-1:0]                    window_now,
	output logic [FLIGHT_W-1:0]                 outstanding,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queued,
	output logic                                dropped
);

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SH_W  = FLIGHT_W + WINDOW_FRAC_BITS;
	localparam int CMP_W = (SH_W > WIN_W) ? SH_W : WIN_W;
	localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1) << WINDOW_FRAC_BITS;
	localparam logic [WIN_W-1:0] WIN_RST = (WIN_RESET < WIN_ONE) ? WIN_ONE : WIN_RESET;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_OUT    = 3'd3;

	logic [2:0]          state_q;
	logic [WIN_W-1:0]    cwnd_q;
	logic [RWND_W-1:0]   rwnd_q;
	logic [FLIGHT_W-1:0] flight_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CNT_W-1:0]    count_q;

	logic                busy_pend_q;
	logic                drop_pend_q;
	logic                sent_pend_q;
	logic [SEQ_W-1:0]    seq_pend_q;

	logic [BYTES_W-1:0]  queue_mem [QUEUE_DEPTH];
	logic [BYTES_W-1:0]  rd_data_q;

	logic                out_valid_q;
	logic                sent_q;
	logic [SEQ_W-1:0]    sent_seq_q;
	logic [BYTES_W-1:0]  sent_bytes_q;
	logic [WIN_W-1:0]    window_q;
	logic [FLIGHT_W-1:0] outstanding_q;
	logic [CNT_W-1:0]    queued_q;
	logic                dropped_q;

	logic                    in_xfer;
	logic                    q_full;
	logic                    push;
	logic                    pop;
	logic                    send_ok;
	logic                    out_load;
	logic                    div_start;
	logic                    div_done;
	logic [WINDOW_FRAC_BITS:0] div_quo;
	logic [WIN_W:0]          grow_sum;
	logic [WIN_W-1:0]        half_win;
	logic [WIN_W-1:0]        cfg_win;
	logic [CMP_W-1:0]        flight_sh;
	logic [CMP_W-1:0]        win_ext;

	// Handshake and event decode
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		in_xfer   = in_valid && in_ready;
		q_full    = (count_q == CNT_W'(QUEUE_DEPTH));
		push      = in_xfer && (mode == MODE_DATA) && !q_full;
		div_start = in_xfer && (mode == MODE_ACK) && !ack_congested;
		out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	// Window arithmetic
	always_comb begin
		grow_sum  = {1'b0, cwnd_q} + (WIN_W + 1)'(div_quo);
		half_win  = cwnd_q >> 1;
		cfg_win   = cfg_data[WIN_W-1:0];
		flight_sh = CMP_W'({flight_q, {WINDOW_FRAC_BITS{1'b0}}});
		win_ext   = CMP_W'(cwnd_q);
		send_ok   = (count_q != '0) && !busy_pend_q && (flight_q < rwnd_q) &&
			(flight_sh < win_ext);
		pop       = (state_q == ST_DECIDE) && send_ok;
	end

	aws_recip #(
		.FRAC_BITS (WINDOW_FRAC_BITS)
	) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (cwnd_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sender state and event sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cwnd_q      <= WIN_RST;
			rwnd_q      <= RWND_RESET;
			flight_q    <= '0;
			seq_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			busy_pend_q <= 1'b0;
			drop_pend_q <= 1'b0;
			sent_pend_q <= 1'b0;
			seq_pend_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == REG_INIT_WINDOW) begin
							cwnd_q <= (cfg_win < WIN_ONE) ? WIN_ONE : cfg_win;
						end else begin
							rwnd_q <= cfg_data[RWND_W-1:0];
						end
					end
					if (in_xfer) begin
						busy_pend_q <= line_busy;
						drop_pend_q <= (mode == MODE_DATA) && q_full;
						state_q     <= ST_DECIDE;
						if (push) begin
							tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
							count_q <= count_q + CNT_W'(1);
						end
						if (mode == MODE_ACK) begin
							rwnd_q <= ack_window;
							if (flight_q != '0) begin
								flight_q <= flight_q - FLIGHT_W'(1);
							end
							if (ack_congested) begin
								cwnd_q <= (half_win < WIN_ONE) ? WIN_ONE : half_win;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					// additive increase, saturate at the top of the window range
					if (div_done) begin
						cwnd_q  <= grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					sent_pend_q <= send_ok;
					seq_pend_q  <= seq_q;
					if (send_ok) begin
						head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
						count_q <= count_q - CNT_W'(1);
						seq_q   <= seq_q + SEQ_W'(1);
						if (flight_q != {FLIGHT_W{1'b1}}) begin
							flight_q <= flight_q + FLIGHT_W'(1);
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Length queue: write on push, read the head on a pop in the decide state
	always_ff @(posedge clk) begin
		if (push) begin
			queue_mem[tail_q] <= packet_bytes;
		end
		if (pop) begin
			rd_data_q <= queue_mem[head_q];
		end
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sent_q        <= sent_pend_q;
			sent_seq_q    <= sent_pend_q ? seq_pend_q : '0;
			sent_bytes_q  <= sent_pend_q ? rd_data_q : '0;
			window_q      <= cwnd_q;
			outstanding_q <= flight_q;
			queued_q      <= count_q;
			dropped_q     <= drop_pend_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sent        = sent_q;
	assign sent_seq    = sent_seq_q;
	assign sent_bytes  = sent_bytes_q;
	assign window_now  = window_q;
	assign outstanding = outstanding_q;
	assign queued      = queued_q;
	assign dropped     = dropped_q;

endmodule

@@ rtl/aws_checker.sv @@
// ----------------------------------------------------------------------------
// aws_checker: port-level checks of the AIMD window sender
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module aws_checker
	import aws_pkg::*;
#(
	parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
	parameter int WINDOW_FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                sent,
	input  logic [SEQ_W-1:0]                    sent_seq,
	input  logic [BYTES_W-1:0]                  sent_bytes,
	input  logic [WIN_W-1:0]                    window_now,
	input  logic [FLIGHT_W-1:0]                 outstanding,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    queued,
	input  logic                                dropped
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1) << WINDOW_FRAC_BITS;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sent) && $stable(sent_seq) &&
			$stable(sent_bytes) && $stable(window_now) && $stable(queued))
		else $error("result changed while stalled");

	// No release: sequence and length read as zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sent |-> sent_seq == '0 && sent_bytes == '0)
		else $error("nonzero send fields without a release");

	// The window never falls below one packet
	a_win_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_now >= WIN_ONE)
		else $error("congestion window below one");

	// A drop without a release leaves the queue full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped && !sent |-> queued == CNT_W'(QUEUE_DEPTH))
		else $error("drop reported with room in the queue");

	// A release leaves at least one packet in flight
	a_sent_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sent |-> outstanding != '0)
		else $error("release with nothing in flight");

endmodule

bind aimd_window_sender aws_checker #(
	.QUEUE_DEPTH      (QUEUE_DEPTH),
	.WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
) u_aws_checker (.*);
